### design/apm_pkg.sv
// package for the automaton pattern matcher
// widths, configuration register codes and shared types; no dependencies

package apm_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int SYM_W       = 8;
  localparam int STATE_W     = $clog2(MAX_PATTERN + 1);
  localparam int LEN_W       = 4;
  localparam int INDEX_W     = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_CHARS  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } cfg_reg_t;

  typedef logic [MAX_PATTERN-1:0][SYM_W-1:0] pattern_t;
  typedef logic [STATE_W-1:0] state_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [INDEX_W-1:0] index_t;

endpackage

### design/apm_text_if.sv
// text byte channel of the pattern matcher
// depends on apm_pkg

interface apm_text_if;
  import apm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SYM_W-1:0]    symbol;
  logic                first_of_text;
  logic                last_of_text;

  modport source (output valid, symbol, first_of_text, last_of_text, input ready);
  modport sink (input valid, symbol, first_of_text, last_of_text, output ready);
endinterface

### design/apm_result_if.sv
// result channel of the pattern matcher
// depends on apm_pkg

interface apm_result_if;
  import apm_pkg::*;

  logic         valid;
  logic         ready;
  logic         found;
  index_t       match_start;
  logic         not_found;

  modport source (output valid, found, match_start, not_found, input ready);
  modport sink (input valid, found, match_start, not_found, output ready);
endinterface

### design/apm_cfg_if.sv
// configuration write channel of the pattern matcher
// depends on apm_pkg

interface apm_cfg_if;
  import apm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/apm_next_state.sv
// next match state of the string-matching automaton, by parallel prefix compare
// depends on apm_pkg

module apm_next_state
  import apm_pkg::*;
(
  input  pattern_t         pattern,
  input  len_t             len,
  input  state_t           state,
  input  logic [SYM_W-1:0] symbol,
  output state_t           state_next
);

  logic [MAX_PATTERN:1] border [0:MAX_PATTERN];
  logic [MAX_PATTERN:1] row;
  logic [MAX_PATTERN:1] hit;

  // border[q][k]: prefix of length k-1 equals pattern bytes q+1-k .. q-1
  always_comb begin
    for (int q = 0; q <= MAX_PATTERN; q++) begin
      for (int k = 1; k <= MAX_PATTERN; k++) begin
        border[q][k] = (k <= q + 1);
        for (int j = 0; j < MAX_PATTERN - 1; j++) begin
          if (k <= q + 1 && j < k - 1) begin
            if (pattern[j] != pattern[q + 1 - k + j]) begin
              border[q][k] = 1'b0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    row = border[state];
    state_next = '0;
    for (int k = 1; k <= MAX_PATTERN; k++) begin
      hit[k] = row[k] && (pattern[k-1] == symbol) && (LEN_W'(k) <= len);
      if (hit[k]) begin
        state_next = STATE_W'(k);
      end
    end
  end

endmodule

### design/automaton_pattern_matcher_top.sv
// Streaming string matcher: takes one text byte per cycle and sustains that rate
// under no stall; each byte gives one result beat, via the input register and
// then the result register; the match-state loop through the prefix comparator
// sets the rate. The user must write the pattern (up to 8 bytes) and its length
// via the cfg channel only while no bytes are in flight; the block does not check.
// depends on apm_pkg, apm_text_if, apm_result_if, apm_cfg_if, apm_next_state

module automaton_pattern_matcher_top
  import apm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  apm_text_if.sink  text,
  apm_result_if.source result,
  apm_cfg_if.sink   cfg
);

  pattern_t         pattern_chars;
  len_t             pattern_length;

  logic             s1_valid;
  logic [SYM_W-1:0] s1_symbol;
  logic             s1_first;
  logic             s1_last;

  state_t           match_state;
  index_t           text_index;
  logic             already_matched;

  logic             out_valid;
  logic             out_found;
  index_t           out_start;
  logic             out_not_found;

  logic             advance;
  len_t             len_eff;
  state_t           q_cur;
  state_t           q_clamp;
  state_t           match_state_next;
  index_t           pos;
  logic             already_cur;
  logic             found_next;
  logic             already_matched_next;
  index_t           start_next;
  index_t           text_index_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars  <= '0;
      pattern_length <= LEN_W'(1);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_PATTERN_CHARS:  pattern_chars  <= cfg.data;
        REG_PATTERN_LENGTH: pattern_length <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign text.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_symbol <= text.symbol;
      s1_first  <= text.first_of_text;
      s1_last   <= text.last_of_text;
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
    q_cur       = s1_first ? '0 : match_state;
    pos         = s1_first ? '0 : text_index;
    already_cur = s1_first ? 1'b0 : already_matched;
    q_clamp     = (STATE_W'(q_cur) > STATE_W'(len_eff)) ? STATE_W'(len_eff) : q_cur;
  end

  apm_next_state u_next_state (
    .pattern    (pattern_chars),
    .len        (len_eff),
    .state      (q_clamp),
    .symbol     (s1_symbol),
    .state_next (match_state_next)
  );

  always_comb begin
    found_next           = (STATE_W'(len_eff) == match_state_next) && !already_cur;
    already_matched_next = already_cur || found_next;
    start_next           = found_next ? (pos - INDEX_W'(len_eff) + INDEX_W'(1)) : '0;
    text_index_next      = (pos == '1) ? pos : pos + INDEX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_state     <= '0;
      text_index      <= '0;
      already_matched <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (advance) begin
        match_state     <= match_state_next;
        text_index      <= text_index_next;
        already_matched <= already_matched_next;
        out_valid       <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_found     <= found_next;
      out_start     <= start_next;
      out_not_found <= s1_last && !already_matched_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.found       = out_found;
  assign result.match_start = out_start;
  assign result.not_found   = out_not_found;

endmodule

### design/apm_checker.sv
// port-level checks for the automaton pattern matcher, bound to the top level
// depends on apm_pkg, automaton_pattern_matcher_top and its result channel

module apm_checker
  import apm_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   res_valid,
  input logic   res_ready,
  input logic   res_found,
  input index_t res_start,
  input logic   res_not_found
);

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat present right after reset");

  a_found_excludes_not_found: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_found && res_not_found))
    else $error("found and not_found in one beat");

  a_start_zero_without_match: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_found) |-> (res_start == '0))
    else $error("match_start nonzero without a match");

  a_stalled_beat_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_found)
      && $stable(res_start) && $stable(res_not_found)))
    else $error("stalled result beat changed");

endmodule

bind automaton_pattern_matcher_top apm_checker u_apm_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_found     (result.found),
  .res_start     (result.match_start),
  .res_not_found (result.not_found)
);
